[design/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character lookup for the base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  // job queue between the byte front end and the character back end
  localparam int JOB_QUEUE_DEPTH = 2;

  localparam int MAX_CHARS = 4;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // one accepted byte turned into its characters
  typedef struct packed {
    logic [MAX_CHARS-1:0][5:0] sym;
    logic [MAX_CHARS-1:0]      pad;
    logic [2:0]                n_chars;
    logic                      last;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ext;
    ext = {2'b00, v};
    if (v < 6'd26) begin
      return CHAR_UP_A + ext;
    end else if (v < 6'd52) begin
      return CHAR_LOW_A + ext - 8'd26;
    end else if (v < 6'd62) begin
      return CHAR_ZERO + ext - 8'd52;
    end else if (v == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

`default_nettype wire

[design/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, tracks the position in the three-byte group and turns
// each byte into a job of one to four characters.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire b64e_pkg::in_item_t in_item,
  output b64e_pkg::job_t         job
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t     group_phase_r, group_phase_nxt;
  logic [3:0] leftover_bits_r, leftover_bits_nxt;

  logic [7:0] b;
  logic       last;

  assign b    = in_item.data_byte;
  assign last = in_item.is_last;

  always_comb begin
    job               = '0;
    group_phase_nxt   = PH_FIRST;
    leftover_bits_nxt = 4'd0;
    case (group_phase_r)
      PH_SECOND: begin
        job.sym[0] = {leftover_bits_r[1:0], b[7:4]};
        if (last) begin
          job.sym[1]  = {b[3:0], 2'b00};
          job.pad[2]  = 1'b1;
          job.n_chars = 3'd3;
          job.last    = 1'b1;
        end else begin
          job.n_chars       = 3'd1;
          leftover_bits_nxt = b[3:0];
          group_phase_nxt   = PH_THIRD;
        end
      end
      PH_THIRD: begin
        job.sym[0]  = {leftover_bits_r, b[7:6]};
        job.sym[1]  = b[5:0];
        job.n_chars = 3'd2;
        job.last    = last;
      end
      default: begin
        // first phase, and the unused phase code, behave as the start of a group
        job.sym[0] = b[7:2];
        if (last) begin
          job.sym[1]  = {b[1:0], 4'b0000};
          job.pad[2]  = 1'b1;
          job.pad[3]  = 1'b1;
          job.n_chars = 3'd4;
          job.last    = 1'b1;
        end else begin
          job.n_chars       = 3'd1;
          leftover_bits_nxt = {2'b00, b[1:0]};
          group_phase_nxt   = PH_SECOND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_phase_r   <= PH_FIRST;
      leftover_bits_r <= 4'd0;
    end else if (accept) begin
      group_phase_r   <= group_phase_nxt;
      leftover_bits_r <= leftover_bits_nxt;
    end
  end

endmodule

`default_nettype wire

[design/b64e_job_fifo.sv]
// ----------------------------------------------------------------------------
// b64e_job_fifo
// Short queue of character jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_job_fifo #(
  parameter int DEPTH = b64e_pkg::JOB_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire b64e_pkg::job_t wr_job,
  input  wire logic           rd_en,
  output b64e_pkg::job_t      rd_job,
  output logic                q_full,
  output logic                q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  b64e_pkg::job_t   slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign q_full  = (count_r == FULL_CNT);
  assign q_empty = (count_r == '0);
  assign rd_job  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !wr_en || rd_en)
    else $error("job written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !rd_en)
    else $error("job read from an empty queue");

endmodule

`default_nettype wire

[design/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per cycle into the output register while that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire b64e_pkg::job_t head_job,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output b64e_pkg::out_item_t out_item
);

  logic                valid_r;
  b64e_pkg::out_item_t out_item_r, out_item_nxt;
  logic [1:0]          idx_r;
  logic                advance, take, final_char;

  // output register frees up when empty or its beat is taken this cycle
  assign advance    = !valid_r || pop;
  assign take       = advance && !q_empty;
  assign final_char = ({1'b0, idx_r} == head_job.n_chars - 3'd1);
  assign q_pop      = take && final_char;

  always_comb begin
    out_item_nxt.out_char  = head_job.pad[idx_r] ? b64e_pkg::PAD_CHAR
                                                 : b64e_pkg::b64_char(head_job.sym[idx_r]);
    out_item_nxt.last_char = head_job.last && final_char;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (take) begin
        valid_r <= 1'b1;
        idx_r   <= final_char ? 2'd0 : idx_r + 2'd1;
      end else if (advance) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign empty    = !valid_r;
  assign out_item = out_item_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> ({1'b0, idx_r} < head_job.n_chars))
    else $error("character index beyond the head job");

  a_idx_clear_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> idx_r == 2'd0)
    else $error("character index left mid-job with no job queued");

endmodule

`default_nettype wire

[design/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming padded base64 encoder, one raw byte in, one character out a beat.
// ----------------------------------------------------------------------------
// A byte beat is taken whenever the job queue has room, so bytes can arrive
// back to back; the front end turns each byte into one to four characters
// and the back end sends out one character per cycle while pops keep up. The
// output side sets the sustained rate: a byte in the middle of a group costs
// one or two characters (four characters per three bytes, about 1.33 per
// byte), and a last byte costs up to four characters for its flushed
// character and '=' padding. The output register lets a new byte be taken
// while a character waits to be popped.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::JOB_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire b64e_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output b64e_pkg::out_item_t      out_item
);

  b64e_pkg::job_t new_job, head_job;
  logic           accept, q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .job     (new_job)
  );

  b64e_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_job  (new_job),
    .rd_en   (q_pop),
    .rd_job  (head_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
